@@ sv/block_bitmap_allocator_assert.svh @@
// Assertion helpers shared by the allocator modules.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Clocked check, off while reset is held.
`define BBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define BBA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

@@ sv/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int BLK_W      = 16;
  localparam int CFG_W      = 17;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam int ADDR_CAP          = 65536;
  localparam int DEF_MAX_BLOCKS    = 65536;
  localparam int DEF_MAP_WORD_BITS = 64;

  localparam logic [CFG_W-1:0] COUNT_MAX = {CFG_W{1'b1}};
  localparam logic [CFG_W-1:0] TOTAL_RST = CFG_W'(65536);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_NO_FREE      = 2'd1,
    STAT_RANGE        = 2'd2,
    STAT_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_RD,
    S_RMW,
    S_SCAN,
    S_GRP,
    S_BIT,
    S_AWR,
    S_FIN
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic set_nofree;
    logic set_range;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic rd_word;
    logic rmw;
    logic find_grp;
    logic find_bit;
    logic alloc_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic no_free;
    logic out_range;
    logic scan_end;
    logic scan_hit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/bba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "block_bitmap_allocator_assert.svh"

module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t      cmd_o
);

  bba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bba_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bba_pkg::S_CHECK;
      end
      bba_pkg::S_CHECK: begin
        if (sts_i.is_alloc) begin
          state_d = sts_i.no_free ? bba_pkg::S_FIN : bba_pkg::S_SCAN;
        end else begin
          state_d = sts_i.out_range ? bba_pkg::S_FIN : bba_pkg::S_DIV;
        end
      end
      bba_pkg::S_DIV: state_d = bba_pkg::S_RD;
      bba_pkg::S_RD:  state_d = bba_pkg::S_RMW;
      bba_pkg::S_RMW: state_d = bba_pkg::S_FIN;
      bba_pkg::S_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = bba_pkg::S_FIN;
        end else if (sts_i.scan_hit) begin
          state_d = bba_pkg::S_GRP;
        end
      end
      bba_pkg::S_GRP: state_d = bba_pkg::S_BIT;
      bba_pkg::S_BIT: state_d = bba_pkg::S_AWR;
      bba_pkg::S_AWR: state_d = bba_pkg::S_FIN;
      bba_pkg::S_FIN: begin
        if (sts_i.out_free) state_d = bba_pkg::S_IDLE;
      end
      default: state_d = bba_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bba_pkg::S_CLEAR: cmd_o.clr_wr = 1'b1;
      bba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      bba_pkg::S_CHECK: begin
        if (sts_i.is_alloc) begin
          cmd_o.set_nofree = sts_i.no_free;
          cmd_o.scan_start = !sts_i.no_free;
        end else begin
          cmd_o.set_range = sts_i.out_range;
          cmd_o.div_start = !sts_i.out_range;
        end
      end
      bba_pkg::S_DIV:  cmd_o.div_step = 1'b1;
      bba_pkg::S_RD:   cmd_o.rd_word  = 1'b1;
      bba_pkg::S_RMW:  cmd_o.rmw      = 1'b1;
      bba_pkg::S_SCAN: begin
        cmd_o.scan_step  = 1'b1;
        cmd_o.set_nofree = sts_i.scan_end;
      end
      bba_pkg::S_GRP:  cmd_o.find_grp = 1'b1;
      bba_pkg::S_BIT:  cmd_o.find_bit = 1'b1;
      bba_pkg::S_AWR:  cmd_o.alloc_wr = 1'b1;
      bba_pkg::S_FIN:  cmd_o.load_out = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  `BBA_ASSERT(a_load_needs_slot, cmd_o.load_out |-> sts_i.out_free, "result loaded over a held one")
  `BBA_ASSERT(a_fin_to_idle, cmd_o.load_out |=> (state_q == bba_pkg::S_IDLE), "no idle after result")

endmodule

`default_nettype wire

@@ sv/bba_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "block_bitmap_allocator_assert.svh"

module bba_dp #(
  parameter int MAX_BLOCKS    = bba_pkg::DEF_MAX_BLOCKS,
  parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [bba_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic [bba_pkg::MODE_W-1:0] in_mode_i,
  input  wire logic [bba_pkg::BLK_W-1:0]  in_block_i,
  input  wire logic                       in_bit_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [bba_pkg::BLK_W-1:0]       out_block_o,
  output logic                            out_bit_o,
  output logic [bba_pkg::STAT_W-1:0]      out_status_o,
  output logic [bba_pkg::CFG_W-1:0]       out_free_o,
  input  wire bba_pkg::cmd_t              cmd_i,
  output bba_pkg::sts_t                   sts_o
);

  localparam int MWB       = MAP_WORD_BITS;
  localparam int MAP_WORDS = (MAX_BLOCKS + MWB - 1) / MWB;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(MWB);
  localparam int NG        = (MWB + 7) / 8;
  localparam int GW        = (NG > 1) ? $clog2(NG) : 1;
  localparam int CAP       = (MAX_BLOCKS < bba_pkg::ADDR_CAP) ? MAX_BLOCKS : bba_pkg::ADDR_CAP;
  localparam int CW        = bba_pkg::CFG_W;
  localparam int BLW       = bba_pkg::BLK_W;

  // word index = (block * RECIP) >> SH, exact for every 16-bit block number
  localparam int SH        = BLW + BW;
  localparam int RECIP     = ((1 << SH) + MWB - 1) / MWB;
  localparam int RCW       = BLW + 1;
  localparam int PW        = BLW + RCW;

  localparam logic [CW-1:0]  CAP_V     = CW'(CAP);
  localparam logic [WW-1:0]  LAST_WORD = WW'(MAP_WORDS - 1);
  localparam logic [CW-1:0]  MWB_C     = CW'(MWB);
  localparam logic [BLW-1:0] MWB_B     = BLW'(MWB);
  localparam logic [RCW-1:0] RECIP_V   = RCW'(RECIP);
  localparam logic [MWB-1:0] ONE_BIT   = MWB'(1);

  // map word: bit b holds block (word * MWB + b), lowest block at bit 0
  logic [MWB-1:0] mem [MAP_WORDS];
  logic [MWB-1:0] rdata_q;

  logic [CW-1:0]  total_q;
  logic [CW-1:0]  used_q;
  logic [WW-1:0]  clr_cnt_q;
  logic [WW-1:0]  chk_w_q;
  logic [CW-1:0]  base_q;
  logic           ovalid_q;

  bba_pkg::mode_e   mode_q;
  logic [BLW-1:0]   blk_q;
  logic             val_q;
  logic [BLW-1:0]   dq_q;
  logic [BW-1:0]    rem_q;
  logic [MWB-1:0]   fv_q;
  logic [GW-1:0]    grp_q;
  logic [BW-1:0]    off_q;
  logic [BLW-1:0]   res_block_q;
  logic             old_q;
  bba_pkg::status_e stat_q;

  logic [BLW-1:0]   out_block_q;
  logic             out_bit_q;
  bba_pkg::status_e out_stat_q;
  logic [CW-1:0]    out_free_q;

  logic [CW-1:0]  lim;
  logic [CW-1:0]  free_now;
  logic [CW-1:0]  span;
  logic [MWB-1:0] vmask;
  logic [MWB-1:0] fv;
  logic           scan_end;
  logic           scan_hit;

  logic [PW-1:0]  div_prod;
  logic [BLW-1:0] div_q;
  logic [BLW-1:0] div_back;
  logic [BLW-1:0] rem_full;

  logic [NG*8-1:0] fvp;
  logic [GW-1:0]   gsel;
  logic [7:0]      gbyte;
  logic [2:0]      bsel;
  logic [BW-1:0]   off_d;
  logic [CW-1:0]   found;

  logic [BW-1:0]  rmw_idx;
  logic [MWB-1:0] rmw_mask;
  logic           rmw_old;

  logic           mem_we;
  logic [WW-1:0]  mem_waddr;
  logic [MWB-1:0] mem_wdata;
  logic           mem_re;
  logic [WW-1:0]  mem_raddr;
  logic           out_free;

  assign lim      = (total_q > CAP_V) ? CAP_V : total_q;
  assign free_now = (used_q >= lim) ? '0 : (lim - used_q);
  assign out_free = !ovalid_q || out_ready_i;

  // scan: free bits below the limit in the word just read
  assign span     = lim - base_q;
  assign scan_end = (base_q >= lim);
  always_comb begin
    for (int b = 0; b < MWB; b++) begin
      vmask[b] = (CW'(b) < span);
    end
  end
  assign fv       = ~rdata_q & vmask;
  assign scan_hit = !scan_end && (|fv);

  // word index by reciprocal multiply, bit index from the remainder next cycle
  assign div_prod = PW'(blk_q) * PW'(RECIP_V);
  assign div_q    = BLW'(div_prod >> SH);
  assign div_back = dq_q * MWB_B;
  assign rem_full = blk_q - div_back;

  // first free bit: pick byte group, then bit within it
  always_comb begin
    fvp          = '0;
    fvp[MWB-1:0] = fv_q;
    gsel         = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (|fvp[g*8 +: 8]) gsel = GW'(g);
    end
  end

  always_comb begin
    gbyte = fvp[{grp_q, 3'b000} +: 8];
    bsel  = '0;
    for (int i = 7; i >= 0; i--) begin
      if (gbyte[i]) bsel = 3'(i);
    end
    off_d = BW'({grp_q, bsel});
  end

  assign found = base_q + CW'(off_q);

  assign rmw_idx  = rem_q;
  assign rmw_mask = ONE_BIT << rmw_idx;
  assign rmw_old  = rdata_q[rmw_idx];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.alloc_wr) begin
      mem_we    = 1'b1;
      mem_waddr = chk_w_q;
      mem_wdata = rdata_q | (ONE_BIT << off_q);
    end else if (cmd_i.rmw) begin
      mem_waddr = WW'(dq_q);
      case (mode_q)
        bba_pkg::MODE_FREE: begin
          mem_we    = rmw_old;
          mem_wdata = rdata_q & ~rmw_mask;
        end
        bba_pkg::MODE_WRITE: begin
          mem_we    = 1'b1;
          mem_wdata = val_q ? (rdata_q | rmw_mask) : (rdata_q & ~rmw_mask);
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd_i.scan_start) begin
      mem_re = 1'b1;
    end else if (cmd_i.scan_step) begin
      mem_re    = !scan_hit && !scan_end;
      mem_raddr = (chk_w_q == LAST_WORD) ? LAST_WORD : (chk_w_q + WW'(1));
    end else if (cmd_i.rd_word) begin
      mem_re    = 1'b1;
      mem_raddr = WW'(dq_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= bba_pkg::TOTAL_RST;
      used_q    <= '0;
      clr_cnt_q <= '0;
      chk_w_q   <= '0;
      base_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) total_q <= cfg_data_i;
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + WW'(1);
      if (cmd_i.scan_start) begin
        chk_w_q <= '0;
        base_q  <= '0;
      end else if (cmd_i.scan_step && !scan_hit && !scan_end) begin
        chk_w_q <= chk_w_q + WW'(1);
        base_q  <= base_q + MWB_C;
      end
      if (cmd_i.alloc_wr && (used_q != bba_pkg::COUNT_MAX)) begin
        used_q <= used_q + CW'(1);
      end else if (cmd_i.rmw && (mode_q == bba_pkg::MODE_FREE) && rmw_old
                   && (used_q != '0)) begin
        used_q <= used_q - CW'(1);
      end
      if (cmd_i.load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q      <= bba_pkg::mode_e'(in_mode_i);
      blk_q       <= in_block_i;
      val_q       <= in_bit_i;
      res_block_q <= in_block_i;
      old_q       <= 1'b0;
      stat_q      <= bba_pkg::STAT_OK;
    end
    if (cmd_i.set_nofree) begin
      res_block_q <= '0;
      stat_q      <= bba_pkg::STAT_NO_FREE;
    end
    if (cmd_i.set_range) stat_q <= bba_pkg::STAT_RANGE;
    if (cmd_i.div_start) dq_q <= div_q;
    if (cmd_i.div_step) rem_q <= rem_full[BW-1:0];
    if (cmd_i.scan_step && scan_hit) fv_q <= fv;
    if (cmd_i.find_grp) grp_q <= gsel;
    if (cmd_i.find_bit) off_q <= off_d;
    if (cmd_i.alloc_wr) res_block_q <= found[BLW-1:0];
    if (cmd_i.rmw) begin
      old_q <= rmw_old;
      if ((mode_q == bba_pkg::MODE_FREE) && !rmw_old) stat_q <= bba_pkg::STAT_ALREADY_FREE;
    end
    if (cmd_i.load_out) begin
      out_block_q <= res_block_q;
      out_bit_q   <= old_q;
      out_stat_q  <= stat_q;
      out_free_q  <= free_now;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = (clr_cnt_q == LAST_WORD);
    sts_o.is_alloc  = (mode_q == bba_pkg::MODE_ALLOC);
    sts_o.no_free   = (free_now == '0);
    sts_o.out_range = ({1'b0, blk_q} >= lim);
    sts_o.scan_end  = scan_end;
    sts_o.scan_hit  = scan_hit;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o  = ovalid_q;
  assign out_block_o  = out_block_q;
  assign out_bit_o    = out_bit_q;
  assign out_status_o = out_stat_q;
  assign out_free_o   = out_free_q;

  `BBA_ASSERT(a_alloc_bit_was_free, cmd_i.alloc_wr |-> !rdata_q[off_q], "allocated a used block")
  `BBA_ASSERT(a_alloc_count, (cmd_i.alloc_wr && (used_q != bba_pkg::COUNT_MAX)) |=> (used_q == ($past(used_q) + CW'(1))), "used count not bumped")

endmodule

`default_nettype wire

@@ sv/block_bitmap_allocator.sv @@
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: block_number, bit_value; tuser: mode
// m_axis    out  tvalid/tready          tdata: result_block, bit_read, free_count; tuser: status
// cfg       in   cfg_valid/cfg_ready    cfg_data: total_blocks
//
// After reset a clearing pass zeroes the map, one word a cycle (all MAP_WORDS words,
// 1024 at defaults); no request is taken until it ends.
// Allocate: map words are scanned at one read per cycle, then the byte group, the bit and the map write.
// Free, write, read: multiply for word, remainder for bit, map read, then write-back for free and write.
// Range error or full map at the check: straight to the result. A finished result waits in the output register;
// the next request is taken meanwhile, and its result stalls until that one leaves.
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_allocator #(
  parameter int MAX_BLOCKS    = bba_pkg::DEF_MAX_BLOCKS,
  parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // block_number [15:0], bit_value [16], zero [23:17]
  input  wire logic [bba_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // mode [1:0]
  input  wire logic [bba_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // result_block [15:0], bit_read [16], free_count [33:17], zero [39:34]
  output logic [bba_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // status [1:0]
  output logic [bba_pkg::OUT_USER_W-1:0]      m_axis_tuser_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bba_pkg::CFG_W-1:0]      cfg_data_i
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  logic [bba_pkg::BLK_W-1:0]  out_block;
  logic                       out_bit;
  logic [bba_pkg::STAT_W-1:0] out_status;
  logic [bba_pkg::CFG_W-1:0]  out_free;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_mode_i    (s_axis_tuser_i[bba_pkg::MODE_W-1:0]),
    .in_block_i   (s_axis_tdata_i[bba_pkg::BLK_W-1:0]),
    .in_bit_i     (s_axis_tdata_i[bba_pkg::BLK_W]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_block_o  (out_block),
    .out_bit_o    (out_bit),
    .out_status_o (out_status),
    .out_free_o   (out_free),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {6'b000000, out_free, out_bit, out_block};
  assign m_axis_tuser_o = out_status;

endmodule

`default_nettype wire
